[src/rtmf_pkg.sv]
// Package for the TCP rule match filter: header constants, verdict reason codes,
// and the queue item type shared by the front, the queue and the engine.
// No dependencies.
`default_nettype none

package rtmf_pkg;

  // Width of the rule slot index carried by a load transaction.
  localparam int INDEX_W = 4;

  // Number of slots the queue between front and engine holds.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IP_VERSION_FOUR = 4'd4;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;

  localparam logic [1:0] REASON_NOT_TCP  = 2'd0;
  localparam logic [1:0] REASON_NO_MATCH = 2'd1;
  localparam logic [1:0] REASON_MATCH    = 2'd2;

  // What the engine does with one queued transaction.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PKT_TCP,
    OP_PKT_OTHER
  } op_t;

  // One classified transaction. For a load, addr/sport/port are the rule's
  // source address, source port and forbidden destination port. For a packet
  // they are its source address, source port and destination port.
  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic               valid;
    logic [31:0]        addr;
    logic [15:0]        sport;
    logic [15:0]        port;
  } item_t;

endpackage

`default_nettype wire

[src/tcp_rule_match_filter_top.sv]
// Top level of the TCP rule match filter: front classifier, queue and engine.
// Depends on rtmf_pkg, rtmf_front, rtmf_queue and rtmf_engine.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+--------------------------------------
//   input    | start, busy (taken on       | kind, entry_*, ether_type, ip_version,
//            | start high and busy low)    | ip_protocol, pkt_src_addr, pkt_*_port
//   result   | result_strobe (one cycle)   | drop, verdict_reason
//
// The block takes one transaction every cycle while busy is low. A packet
// passes through a queue slot, the slot compare registers and the verdict
// register, and its verdict then shows on result_strobe. The engine drains
// one queue entry per cycle, so the queue holds at most one entry and busy
// stays low in normal use. Reset is synchronous and clears the rule valid
// bits, the queue pointers and the pipeline valid flags. Loads produce no
// result; a load to a slot at or above RULE_SLOTS is discarded.
`default_nettype none

module tcp_rule_match_filter_top #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [3:0]  entry_index,
  input  wire logic        entry_valid,
  input  wire logic [31:0] entry_src_addr,
  input  wire logic [15:0] entry_src_port,
  input  wire logic [15:0] entry_bad_port,
  input  wire logic [15:0] ether_type,
  input  wire logic [3:0]  ip_version,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [31:0] pkt_src_addr,
  input  wire logic [15:0] pkt_src_port,
  input  wire logic [15:0] pkt_dst_port,
  output logic             result_strobe,
  output logic             drop,
  output logic [1:0]       verdict_reason
);

  // Only slots reachable by the index field are built.
  localparam int INDEX_SPAN  = 1 << rtmf_pkg::INDEX_W;
  localparam int NUM_ENTRIES = (RULE_SLOTS < INDEX_SPAN) ? RULE_SLOTS : INDEX_SPAN;
  localparam int CNT_W       = $clog2(rtmf_pkg::QUEUE_DEPTH + 1);

  logic            accept;
  logic            push;
  rtmf_pkg::item_t push_item;
  rtmf_pkg::item_t head;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic [CNT_W-1:0] q_count;

  assign busy   = q_full;
  assign accept = start && !busy;
  // The engine never stalls, so any queued transaction is taken right away.
  assign pop    = !q_empty;

  rtmf_front #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_front (
    .accept         (accept),
    .kind           (kind),
    .entry_index    (entry_index),
    .entry_valid    (entry_valid),
    .entry_src_addr (entry_src_addr),
    .entry_src_port (entry_src_port),
    .entry_bad_port (entry_bad_port),
    .ether_type     (ether_type),
    .ip_version     (ip_version),
    .ip_protocol    (ip_protocol),
    .pkt_src_addr   (pkt_src_addr),
    .pkt_src_port   (pkt_src_port),
    .pkt_dst_port   (pkt_dst_port),
    .push           (push),
    .item           (push_item)
  );

  rtmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head),
    .count     (q_count)
  );

  rtmf_engine #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .run            (pop),
    .item           (head),
    .result_strobe  (result_strobe),
    .drop           (drop),
    .verdict_reason (verdict_reason)
  );

  // Because the engine drains every cycle, the queue never builds up.
  a_queue_shallow: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(1))
    else $error("queue holds more than one transaction");

  // Every verdict comes from a packet that left the queue, never from a load.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(pop, 2) && ($past(head.op, 2) != rtmf_pkg::OP_LOAD))
    else $error("verdict without a matching dequeued packet");

  // A drop is only ever reported with the rule match reason.
  a_drop_reason: assert property (@(posedge clk) disable iff (rst)
    result_strobe && drop |-> verdict_reason == rtmf_pkg::REASON_MATCH)
    else $error("drop reported with a reason other than rule match");

endmodule

`default_nettype wire

[src/rtmf_front.sv]
// Front part of the TCP rule match filter: classifies each accepted transaction
// and forms the queue item. Depends on rtmf_pkg.
`default_nettype none

module rtmf_front #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic                          accept,
  input  wire logic                          kind,
  input  wire logic [rtmf_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic                          entry_valid,
  input  wire logic [31:0]                   entry_src_addr,
  input  wire logic [15:0]                   entry_src_port,
  input  wire logic [15:0]                   entry_bad_port,
  input  wire logic [15:0]                   ether_type,
  input  wire logic [3:0]                    ip_version,
  input  wire logic [7:0]                    ip_protocol,
  input  wire logic [31:0]                   pkt_src_addr,
  input  wire logic [15:0]                   pkt_src_port,
  input  wire logic [15:0]                   pkt_dst_port,
  output logic                               push,
  output rtmf_pkg::item_t                    item
);

  logic index_ok;
  logic is_tcp;

  always_comb begin
    index_ok = (int'(entry_index) < RULE_SLOTS);
    is_tcp   = (ether_type == rtmf_pkg::ETHERTYPE_IPV4) &&
               (ip_version == rtmf_pkg::IP_VERSION_FOUR) &&
               (ip_protocol == rtmf_pkg::PROTO_TCP);
  end

  always_comb begin
    item.index = entry_index;
    item.valid = entry_valid;
    if (!kind) begin
      item.op    = rtmf_pkg::OP_LOAD;
      item.addr  = entry_src_addr;
      item.sport = entry_src_port;
      item.port  = entry_bad_port;
      // A load aimed past the table is dropped here and never queued.
      push       = accept && index_ok;
    end else begin
      item.op    = is_tcp ? rtmf_pkg::OP_PKT_TCP : rtmf_pkg::OP_PKT_OTHER;
      item.addr  = pkt_src_addr;
      item.sport = pkt_src_port;
      item.port  = pkt_dst_port;
      push       = accept;
    end
  end

endmodule

`default_nettype wire

[src/rtmf_queue.sv]
// Short queue between the front and the engine of the TCP rule match filter.
// Depends on rtmf_pkg.
`default_nettype none

module rtmf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rtmf_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output rtmf_pkg::item_t      head,
  output logic [$clog2(rtmf_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(rtmf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rtmf_pkg::QUEUE_DEPTH + 1);

  rtmf_pkg::item_t slots [rtmf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = (count == CNT_W'(rtmf_pkg::QUEUE_DEPTH));
    empty   = (count == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/rtmf_engine.sv]
// Back part of the TCP rule match filter: holds the rule table, applies loads
// and compares packets against every enabled slot. Depends on rtmf_pkg.
`default_nettype none

module rtmf_engine #(
  parameter int NUM_ENTRIES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            run,
  input  wire rtmf_pkg::item_t item,
  output logic                 result_strobe,
  output logic                 drop,
  output logic [1:0]           verdict_reason
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [NUM_ENTRIES-1:0] enabled;
  logic [31:0]            src_addr [NUM_ENTRIES];
  logic [15:0]            src_port [NUM_ENTRIES];
  logic [15:0]            bad_port [NUM_ENTRIES];

  logic [IDX_W-1:0]       wr_idx;
  logic                   is_load;
  logic [NUM_ENTRIES-1:0] slot_hit;

  // Compare stage registers.
  logic                   cmp_valid;
  logic                   cmp_tcp;
  logic [NUM_ENTRIES-1:0] cmp_hits;

  always_comb begin
    wr_idx  = item.index[IDX_W-1:0];
    is_load = run && (item.op == rtmf_pkg::OP_LOAD);
    for (int s = 0; s < NUM_ENTRIES; s++) begin
      slot_hit[s] = enabled[s] &&
                    (((src_addr[s] == item.addr) && (src_port[s] == item.sport)) ||
                     (bad_port[s] == item.port));
    end
  end

  always_ff @(posedge clk) begin
    if (is_load) begin
      src_addr[wr_idx] <= item.addr;
      src_port[wr_idx] <= item.sport;
      bad_port[wr_idx] <= item.port;
    end
    cmp_tcp  <= (item.op == rtmf_pkg::OP_PKT_TCP);
    cmp_hits <= slot_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= '0;
      cmp_valid     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (is_load) begin
        enabled[wr_idx] <= item.valid;
      end
      cmp_valid     <= run && (item.op != rtmf_pkg::OP_LOAD);
      result_strobe <= cmp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmp_tcp) begin
      drop           <= 1'b0;
      verdict_reason <= rtmf_pkg::REASON_NOT_TCP;
    end else if (|cmp_hits) begin
      drop           <= 1'b1;
      verdict_reason <= rtmf_pkg::REASON_MATCH;
    end else begin
      drop           <= 1'b0;
      verdict_reason <= rtmf_pkg::REASON_NO_MATCH;
    end
  end

endmodule

`default_nettype wire
